/* rtl/ritoa_pkg.sv */
// Shared types, constants and helpers for the radix integer-to-ASCII converter.
package ritoa_pkg;

    // Radix register reset value and the valid radix range
    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [5:0] RADIX_MIN   = 6'd2;
    localparam logic [5:0] RADIX_MAX   = 6'd16;
    localparam logic [5:0] RADIX_DEC   = 6'd10;

    // Register decode: word address bit selecting the radix register
    localparam logic REG_RADIX = 1'b0;

    // Character codes
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_A     = 7'h41;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;
    localparam logic [6:0] CHAR_NONE  = 7'h00;

    // Quotient bits retired by the divider in one cycle
    localparam int DIV_STEPS = 4;

    // Classification of one accepted value, front to back
    typedef struct packed {
        logic       bad;    // radix outside 2..16
        logic       sign;   // emit a leading minus
        logic [4:0] radix;  // radix for the divider
    } desc_flags_t;

    // One result character
    typedef struct packed {
        logic [6:0] char_code;
        logic       is_empty;
        logic       last;
    } result_t;

    // Back end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FAIL,
        BK_DIV,
        BK_SIGN,
        BK_READ,
        BK_EMIT
    } back_state_t;

    // Map a digit value to its ASCII character
    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [6:0] ch;
        if (d < 4'd10)
        begin
            ch = CHAR_ZERO + {3'b000, d};
        end
        else
        begin
            ch = CHAR_A + {3'b000, d} - 7'd10;
        end
        return ch;
    endfunction

endpackage

/* rtl/ritoa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ritoa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ritoa_queue.sv */
// Small register-based FIFO used between front and back and at the output.
module ritoa_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW  = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNW-1:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNW'(1);
            2'b01:   count_next = count_reg - CNW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/ritoa_front.sv */
// Front end: radix register, value intake and classification.
module ritoa_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // value intake
    input  logic                           push,
    input  logic signed [VALUE_BITS-1:0]   value,
    output logic                           full,
    // descriptor queue
    input  logic                           desc_full,
    output logic                           desc_push,
    output ritoa_pkg::desc_flags_t         desc_flags,
    output logic [VALUE_BITS-1:0]          desc_mag
);

    logic [5:0]            radix_reg;
    logic                  wr_radix;
    logic                  neg;
    logic                  radix_ok;
    logic [VALUE_BITS-1:0] raw;

    // Register write and read-back
    assign pready   = 1'b1;
    assign wr_radix = psel && penable && pwrite && (paddr[2] == ritoa_pkg::REG_RADIX);
    assign prdata   = (paddr[2] == ritoa_pkg::REG_RADIX) ? {26'd0, radix_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= ritoa_pkg::RADIX_RESET;
        end
        else if (wr_radix)
        begin
            radix_reg <= pwdata[5:0];
        end
    end

    // Classify the incoming value against the current radix
    assign raw      = value;
    assign neg      = raw[VALUE_BITS-1];
    assign radix_ok = (radix_reg >= ritoa_pkg::RADIX_MIN) && (radix_reg <= ritoa_pkg::RADIX_MAX);

    always_comb
    begin
        desc_flags.bad   = !radix_ok;
        desc_flags.sign  = neg && (radix_reg == ritoa_pkg::RADIX_DEC);
        desc_flags.radix = radix_reg[4:0];
        desc_mag         = neg ? (~raw + VALUE_BITS'(1)) : raw;
    end

    // Hand the classified value to the queue
    assign full      = desc_full;
    assign desc_push = push && !desc_full;

endmodule

/* rtl/ritoa_back.sv */
// Back end: iterative radix divider, digit stack and character emitter.
module ritoa_back #(
    parameter int VALUE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // descriptor queue
    input  logic                   desc_valid,
    input  ritoa_pkg::desc_flags_t desc_flags,
    input  logic [VALUE_BITS-1:0]  desc_mag,
    output logic                   desc_pop,
    // result queue
    input  logic                   out_full,
    output logic                   out_push,
    output ritoa_pkg::result_t     out_data
);

    localparam int STEPS    = ritoa_pkg::DIV_STEPS;
    localparam int PAD_BITS = ((VALUE_BITS + STEPS - 1) / STEPS) * STEPS;
    localparam int STEP_CNT = PAD_BITS / STEPS;
    localparam int SCW      = (STEP_CNT > 1) ? $clog2(STEP_CNT) : 1;
    localparam int CW       = $clog2(VALUE_BITS + 1);
    localparam int AW       = $clog2(VALUE_BITS);

    ritoa_pkg::back_state_t state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [SCW-1:0]         step_reg, step_next;
    logic [PAD_BITS-1:0]    quo_reg, quo_next;
    logic [3:0]             rem_reg, rem_next;
    logic [4:0]             radix_reg, radix_next;
    logic                   sign_reg, sign_next;

    logic [PAD_BITS-1:0]    q_step;
    logic [4:0]             r_step;
    logic                   step_last;
    logic                   quo_zero;
    logic [CW-1:0]          cnt_dec;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [AW-1:0]          ram_raddr;
    logic [3:0]             ram_rdata;

    // Divider: retire STEPS quotient bits per cycle by restoring division
    always_comb
    begin
        q_step = quo_reg;
        r_step = {1'b0, rem_reg};
        for (int k = 0; k < STEPS; k++)
        begin
            r_step = {r_step[3:0], q_step[PAD_BITS-1]};
            q_step = {q_step[PAD_BITS-2:0], 1'b0};
            if (r_step >= radix_reg)
            begin
                r_step    = r_step - radix_reg;
                q_step[0] = 1'b1;
            end
        end
    end

    assign step_last = (step_reg == SCW'(STEP_CNT - 1));
    assign quo_zero  = (q_step == '0);
    assign cnt_dec   = cnt_reg - CW'(1);
    assign ram_waddr = cnt_reg[AW-1:0];
    assign ram_raddr = cnt_dec[AW-1:0];

    // Digit stack, least significant digit at address zero
    ritoa_ram #(
        .WIDTH(4),
        .DEPTH(VALUE_BITS)
    ) u_digits (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(r_step[3:0]),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ritoa_pkg::BK_IDLE:
            begin
                if (desc_valid)
                begin
                    state_next = desc_flags.bad ? ritoa_pkg::BK_FAIL : ritoa_pkg::BK_DIV;
                end
            end
            ritoa_pkg::BK_FAIL:
            begin
                if (!out_full)
                begin
                    state_next = ritoa_pkg::BK_IDLE;
                end
            end
            ritoa_pkg::BK_DIV:
            begin
                if (step_last && quo_zero)
                begin
                    state_next = sign_reg ? ritoa_pkg::BK_SIGN : ritoa_pkg::BK_READ;
                end
            end
            ritoa_pkg::BK_SIGN:
            begin
                if (!out_full)
                begin
                    state_next = ritoa_pkg::BK_READ;
                end
            end
            ritoa_pkg::BK_READ:
            begin
                state_next = ritoa_pkg::BK_EMIT;
            end
            ritoa_pkg::BK_EMIT:
            begin
                if (!out_full)
                begin
                    state_next = (cnt_reg == CW'(1)) ? ritoa_pkg::BK_IDLE : ritoa_pkg::BK_READ;
                end
            end
            default:
            begin
                state_next = ritoa_pkg::BK_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        desc_pop           = 1'b0;
        out_push           = 1'b0;
        out_data.char_code = ritoa_pkg::CHAR_NONE;
        out_data.is_empty  = 1'b0;
        out_data.last      = 1'b0;
        ram_we             = 1'b0;
        cnt_next           = cnt_reg;
        step_next          = step_reg;
        quo_next           = quo_reg;
        rem_next           = rem_reg;
        radix_next         = radix_reg;
        sign_next          = sign_reg;
        case (state_reg)
            ritoa_pkg::BK_IDLE:
            begin
                // Load the next classified value
                desc_pop   = desc_valid;
                cnt_next   = '0;
                step_next  = '0;
                quo_next   = PAD_BITS'(desc_mag);
                rem_next   = '0;
                radix_next = desc_flags.radix;
                sign_next  = desc_flags.sign;
            end
            ritoa_pkg::BK_FAIL:
            begin
                out_push          = !out_full;
                out_data.is_empty = 1'b1;
                out_data.last     = 1'b1;
            end
            ritoa_pkg::BK_DIV:
            begin
                quo_next = q_step;
                rem_next = r_step[3:0];
                if (step_last)
                begin
                    // Store the digit and restart on the quotient
                    ram_we    = 1'b1;
                    cnt_next  = cnt_reg + CW'(1);
                    step_next = '0;
                    rem_next  = '0;
                end
                else
                begin
                    step_next = step_reg + SCW'(1);
                end
            end
            ritoa_pkg::BK_SIGN:
            begin
                out_push           = !out_full;
                out_data.char_code = ritoa_pkg::CHAR_MINUS;
            end
            ritoa_pkg::BK_READ:
            begin
                // Wait for the registered stack read
            end
            ritoa_pkg::BK_EMIT:
            begin
                out_push           = !out_full;
                out_data.char_code = ritoa_pkg::digit_char(ram_rdata);
                out_data.last      = (cnt_reg == CW'(1));
                if (!out_full)
                begin
                    cnt_next = cnt_dec;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ritoa_pkg::BK_IDLE;
            cnt_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
        end
    end

    // Divider payload
    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
        sign_reg  <= sign_next;
    end

endmodule

/* rtl/radix_integer_to_ascii.sv */
// Each digit is one restoring division of the quotient by the radix; each character is then
// read from the digit stack (BK_READ) and emitted (BK_EMIT). Throughput: one value at a time
// in the back end; the divider, 4 quotient bits per cycle, sets the pace.
// The front accepts into a 2-entry queue, so it takes new values while the back works.
// Reset: radix register returns to 10, both queues empty, back end idle.
module radix_integer_to_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // value input
    input  logic                         push,
    output logic                         full,
    input  logic signed [VALUE_BITS-1:0] value,
    // character output
    output logic                         empty,
    input  logic                         pop,
    output logic [6:0]                   char_code,
    output logic                         is_empty,
    output logic                         last
);

    localparam int FLAG_BITS = $bits(ritoa_pkg::desc_flags_t);
    localparam int DESC_BITS = FLAG_BITS + VALUE_BITS;
    localparam int RES_BITS  = $bits(ritoa_pkg::result_t);

    logic                   desc_full;
    logic                   desc_push;
    logic                   desc_empty;
    logic                   desc_pop;
    ritoa_pkg::desc_flags_t in_flags;
    ritoa_pkg::desc_flags_t q_flags;
    logic [VALUE_BITS-1:0]  in_mag;
    logic [VALUE_BITS-1:0]  q_mag;
    logic [DESC_BITS-1:0]   desc_wdata;
    logic [DESC_BITS-1:0]   desc_rdata;
    logic                   res_full;
    logic                   res_push;
    ritoa_pkg::result_t     res_in;
    ritoa_pkg::result_t     res_out;

    ritoa_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .push      (push),
        .value     (value),
        .full      (full),
        .desc_full (desc_full),
        .desc_push (desc_push),
        .desc_flags(in_flags),
        .desc_mag  (in_mag)
    );

    // Queue of classified values between front and back
    assign desc_wdata = {in_flags, in_mag};
    assign q_flags    = desc_rdata[VALUE_BITS +: FLAG_BITS];
    assign q_mag      = desc_rdata[VALUE_BITS-1:0];

    ritoa_queue #(
        .WIDTH(DESC_BITS),
        .DEPTH(2)
    ) u_desc_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (desc_push),
        .push_data(desc_wdata),
        .full     (desc_full),
        .pop      (desc_pop),
        .pop_data (desc_rdata),
        .empty    (desc_empty)
    );

    ritoa_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .desc_valid(!desc_empty),
        .desc_flags(q_flags),
        .desc_mag  (q_mag),
        .desc_pop  (desc_pop),
        .out_full  (res_full),
        .out_push  (res_push),
        .out_data  (res_in)
    );

    // Result queue toward the consumer
    ritoa_queue #(
        .WIDTH(RES_BITS),
        .DEPTH(2)
    ) u_res_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_push),
        .push_data(res_in),
        .full     (res_full),
        .pop      (pop),
        .pop_data (res_out),
        .empty    (empty)
    );

    assign char_code = res_out.char_code;
    assign is_empty  = res_out.is_empty;
    assign last      = res_out.last;

endmodule
